// ===== sv/iptp_pkg.sv =====
// ----------------------------------------------------------------------------
// iptp_pkg
// shared types and constants of the address text parser
// ----------------------------------------------------------------------------
package iptp_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic        text_valid;
		logic        is_v4;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [4:0]  range_code;
		logic        mapped_v4;
		logic        is_loopback;
		logic        routable_public;
	} out_item_t;

	// parse snapshot handed from the front part to the back part
	typedef struct packed {
		logic         valid;      // parse accepted
		logic         v4;
		logic [127:0] addr;
	} parsed_t;

	localparam logic [3:0] NO_COMPRESS = 4'd15;
	localparam logic [4:0] RC_PUBLIC   = 5'd0;
	localparam logic [4:0] RC_INVALID  = 5'd1;
	localparam logic [4:0] RC_V4_BASE  = 5'd2;
	localparam logic [4:0] RC_V6_UNSPEC = 5'd17;
	localparam logic [4:0] RC_V6_LOOP  = 5'd18;
	localparam logic [4:0] RC_V6_NAT64 = 5'd19;
	localparam logic [4:0] RC_V6_DISC  = 5'd20;
	localparam logic [4:0] RC_V6_DOC   = 5'd21;
	localparam logic [4:0] RC_V6_LINK  = 5'd22;
	localparam logic [4:0] RC_V6_ULA   = 5'd23;
	localparam logic [4:0] RC_V6_MCAST = 5'd24;

	localparam int V4_RANGES = 15;
	localparam logic [31:0] V4_NET [V4_RANGES] = '{
		32'h00000000, 32'h0A000000, 32'h64400000, 32'h7F000000, 32'hA9FE0000,
		32'hAC100000, 32'hC0000000, 32'hC0000200, 32'hC0586300, 32'hC0A80000,
		32'hC6120000, 32'hC6336400, 32'hCB007100, 32'hE0000000, 32'hF0000000
	};
	localparam logic [5:0] V4_BITS [V4_RANGES] = '{
		6'd8, 6'd8, 6'd10, 6'd8, 6'd16, 6'd12, 6'd24, 6'd24, 6'd24, 6'd16,
		6'd15, 6'd24, 6'd24, 6'd4, 6'd4
	};

	function automatic logic [4:0] v4_code(input logic [31:0] a);
		logic [4:0]  code;
		logic [31:0] m;
		code = RC_PUBLIC;
		for (int i = V4_RANGES - 1; i >= 0; i--) begin
			m = 32'hFFFFFFFF << (6'd32 - V4_BITS[i]);
			if ((a & m) == (V4_NET[i] & m))
				code = RC_V4_BASE + 5'(i);
		end
		return code;
	endfunction

endpackage

// ===== sv/iptp_front.sv =====
// ----------------------------------------------------------------------------
// iptp_front
// per character parser; emits a parse snapshot on the last character
// ----------------------------------------------------------------------------
module iptp_front import iptp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  in_item_t in_item,
	output logic     snap_fire,
	output parsed_t  snap
);

	logic [31:0] v4_octets_q;
	logic [7:0]  dec_value_q;
	logic [1:0]  dec_digits_q;
	logic [1:0]  dot_count_q;
	logic [15:0] hex_groups_q [8];
	logic [3:0]  group_count_q;
	logic [15:0] hex_value_q;
	logic [2:0]  hex_digits_q;
	logic [3:0]  compress_at_q;
	logic        prev_colon_q;
	logic f_colon_q, f_zone_q, f_err_q, f_started_q;
	logic f_segdot_q, f_v4err_q, f_hexerr_q, f_segused_q;

	// next state
	logic [31:0] v4_o;
	logic [7:0]  dec_v;
	logic [1:0]  dec_d, dot_c;
	logic [3:0]  grp_c, cmp_at;
	logic [15:0] hex_v;
	logic [2:0]  hex_d;
	logic        pcol, wr_grp;
	logic f_colon, f_zone, f_err, f_started, f_segdot, f_v4err, f_hexerr, f_segused;
	logic [7:0]  c;
	logic [4:0]  dig;
	logic [9:0]  t;
	logic        is_dec;

	always_comb begin
		c = in_item.char_code;
		v4_o = v4_octets_q; dec_v = dec_value_q; dec_d = dec_digits_q;
		dot_c = dot_count_q; grp_c = group_count_q; cmp_at = compress_at_q;
		hex_v = hex_value_q; hex_d = hex_digits_q; pcol = prev_colon_q;
		f_colon = f_colon_q; f_zone = f_zone_q; f_err = f_err_q;
		f_started = f_started_q; f_segdot = f_segdot_q; f_v4err = f_v4err_q;
		f_hexerr = f_hexerr_q; f_segused = f_segused_q;
		wr_grp = 1'b0;
		is_dec = (c >= 8'h30) && (c <= 8'h39);
		if (is_dec) dig = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) dig = 5'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) dig = 5'(c - 8'h37);
		else dig = 5'd16;
		t = {2'b0, dec_value_q} * 10'd10 + {6'b0, dig[3:0]};
		if (!f_zone_q) begin
			if (c == 8'h25) begin
				f_zone = 1'b1;
			end else if (c == 8'h3A) begin
				f_colon = 1'b1;
				if (prev_colon_q) begin
					if (compress_at_q != NO_COMPRESS) f_err = 1'b1;
					else cmp_at = group_count_q;
				end else if (!f_segused_q) begin
					if (f_started_q) f_err = 1'b1;
				end else if (f_segdot_q || f_hexerr_q || hex_digits_q == 3'd0 ||
						group_count_q >= 4'd8) begin
					f_err = 1'b1;
				end else begin
					wr_grp = 1'b1;
					grp_c = group_count_q + 4'd1;
				end
				pcol = 1'b1;
				f_started = 1'b1;
				v4_o = '0; dec_v = '0; dec_d = '0; dot_c = '0; hex_v = '0; hex_d = '0;
				f_segdot = 1'b0; f_v4err = 1'b0; f_hexerr = 1'b0; f_segused = 1'b0;
			end else begin
				if (prev_colon_q && group_count_q == 4'd0 && compress_at_q == NO_COMPRESS)
					f_err = 1'b1;
				pcol = 1'b0;
				f_started = 1'b1; f_segused = 1'b1;
				if (dig[4] || hex_digits_q >= 3'd4) f_hexerr = 1'b1;
				else begin
					hex_v = {hex_value_q[11:0], dig[3:0]};
					hex_d = hex_digits_q + 3'd1;
				end
				if (is_dec) begin
					if ((dec_digits_q != 2'd0 && dec_value_q == 8'd0) ||
							dec_digits_q == 2'd3 || t > 10'd255)
						f_v4err = 1'b1;
					else begin
						dec_v = t[7:0];
						dec_d = dec_digits_q + 2'd1;
					end
				end else if (c == 8'h2E) begin
					f_segdot = 1'b1;
					if (dec_digits_q == 2'd0 || dot_count_q == 2'd3) f_v4err = 1'b1;
					else begin
						v4_o = {v4_octets_q[23:0], dec_value_q};
						dot_c = dot_count_q + 2'd1;
						dec_v = '0; dec_d = '0;
					end
				end else begin
					f_v4err = 1'b1;
				end
			end
		end
	end

	// finish: group assembly
	logic        quad_ok, ok, valid, v4;
	logic [31:0] a32;
	logic [15:0] g [10];
	logic [15:0] w [8];
	logic [3:0]  n, right;
	logic [127:0] addr;

	always_comb begin
		quad_ok = !f_v4err && dot_c == 2'd3 && dec_d != 2'd0;
		a32 = {v4_o[23:0], dec_v};
		for (int i = 0; i < 8; i++) g[i] = hex_groups_q[i];
		if (wr_grp) g[group_count_q[2:0]] = hex_value_q;
		g[8] = '0; g[9] = '0;
		n = grp_c; ok = 1'b1; valid = 1'b0; v4 = 1'b0; addr = '0;
		for (int i = 0; i < 8; i++) w[i] = '0;
		right = '0;
		if (!f_started) begin
			valid = 1'b0;
		end else if (!f_colon) begin
			if (quad_ok) begin
				valid = 1'b1; v4 = 1'b1; addr = {96'b0, a32};
			end
		end else if (!f_err) begin
			if (pcol) ok = (cmp_at == grp_c);
			else if (f_segdot) begin
				if (!quad_ok || grp_c > 4'd6) ok = 1'b0;
				else begin
					g[grp_c] = a32[31:16]; g[grp_c + 4'd1] = a32[15:0];
					n = grp_c + 4'd2;
				end
			end else begin
				if (f_hexerr || hex_d == 3'd0 || grp_c >= 4'd8) ok = 1'b0;
				else begin
					g[grp_c] = hex_v; n = grp_c + 4'd1;
				end
			end
			if (ok) begin
				if (cmp_at == NO_COMPRESS) begin
					if (n != 4'd8) ok = 1'b0;
					else for (int i = 0; i < 8; i++) w[i] = g[i];
				end else if (n > 4'd7 || cmp_at > n) begin
					ok = 1'b0;
				end else begin
					right = n - cmp_at;
					for (int i = 0; i < 8; i++) begin
						if (4'(i) < cmp_at) w[i] = g[i];
						else if (4'(i) >= 4'd8 - right)
							w[i] = g[4'(i) - (4'd8 - right) + cmp_at];
					end
				end
			end
			if (ok) begin
				valid = 1'b1;
				addr = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_octets_q <= '0; dec_value_q <= '0; dec_digits_q <= '0; dot_count_q <= '0;
			for (int i = 0; i < 8; i++) hex_groups_q[i] <= '0;
			group_count_q <= '0; hex_value_q <= '0; hex_digits_q <= '0;
			compress_at_q <= NO_COMPRESS; prev_colon_q <= 1'b0;
			{f_colon_q, f_zone_q, f_err_q, f_started_q} <= '0;
			{f_segdot_q, f_v4err_q, f_hexerr_q, f_segused_q} <= '0;
			snap_fire <= 1'b0;
		end else begin
			snap_fire <= in_fire && in_item.last_char;
			if (in_fire) begin
				if (in_item.last_char) begin
					v4_octets_q <= '0; dec_value_q <= '0; dec_digits_q <= '0;
					dot_count_q <= '0;
					for (int i = 0; i < 8; i++) hex_groups_q[i] <= '0;
					group_count_q <= '0; hex_value_q <= '0; hex_digits_q <= '0;
					compress_at_q <= NO_COMPRESS; prev_colon_q <= 1'b0;
					{f_colon_q, f_zone_q, f_err_q, f_started_q} <= '0;
					{f_segdot_q, f_v4err_q, f_hexerr_q, f_segused_q} <= '0;
				end else begin
					v4_octets_q <= v4_o; dec_value_q <= dec_v; dec_digits_q <= dec_d;
					dot_count_q <= dot_c;
					if (wr_grp) hex_groups_q[group_count_q[2:0]] <= hex_value_q;
					group_count_q <= grp_c; hex_value_q <= hex_v; hex_digits_q <= hex_d;
					compress_at_q <= cmp_at; prev_colon_q <= pcol;
					{f_colon_q, f_zone_q, f_err_q, f_started_q} <=
						{f_colon, f_zone, f_err, f_started};
					{f_segdot_q, f_v4err_q, f_hexerr_q, f_segused_q} <=
						{f_segdot, f_v4err, f_hexerr, f_segused};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_item.last_char) begin
			snap.valid <= valid;
			snap.v4    <= v4;
			snap.addr  <= addr;
		end
	end

endmodule

// ===== sv/iptp_fifo.sv =====
// ----------------------------------------------------------------------------
// iptp_fifo
// short queue of parse snapshots between front and back parts
// ----------------------------------------------------------------------------
module iptp_fifo import iptp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  parsed_t wr_data,
	output logic    full,
	output logic    rd_valid,
	input  logic    rd_en,
	output parsed_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	parsed_t        mem_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;

	assign full     = cnt_q == (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr_en || rd_en) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== sv/iptp_back.sv =====
// ----------------------------------------------------------------------------
// iptp_back
// range classification of a parsed address, registered output
// ----------------------------------------------------------------------------
module iptp_back import iptp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  parsed_t   in_snap,
	output logic      in_take,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	out_item_t r;
	logic [63:0] hi, lo;

	assign in_take = in_valid && (!out_valid || !out_stall);

	always_comb begin
		hi = in_snap.addr[127:64];
		lo = in_snap.addr[63:0];
		r = '0;
		r.range_code = RC_INVALID;
		if (in_snap.valid) begin
			r.text_valid = 1'b1;
			r.addr_high  = hi;
			r.addr_low   = lo;
			if (in_snap.v4) begin
				r.is_v4 = 1'b1;
				r.range_code = v4_code(lo[31:0]);
				r.is_loopback = lo[31:24] == 8'd127;
			end else if (hi == '0 && lo == '0) r.range_code = RC_V6_UNSPEC;
			else if (hi == '0 && lo == 64'd1) begin
				r.range_code = RC_V6_LOOP; r.is_loopback = 1'b1;
			end else if (hi == '0 && lo[63:32] == 32'h0000FFFF) begin
				r.mapped_v4 = 1'b1; r.range_code = v4_code(lo[31:0]);
			end else if (hi == 64'h0064FF9B00000000 && lo[63:32] == '0)
				r.range_code = RC_V6_NAT64;
			else if (hi == 64'h0100000000000000) r.range_code = RC_V6_DISC;
			else if (hi[63:32] == 32'h20010DB8) r.range_code = RC_V6_DOC;
			else if (hi[63:54] == 10'h3FA) r.range_code = RC_V6_LINK;
			else if (hi[63:57] == 7'h7E) r.range_code = RC_V6_ULA;
			else if (hi[63:56] == 8'hFF) r.range_code = RC_V6_MCAST;
			else r.range_code = RC_PUBLIC;
			r.routable_public = r.range_code == RC_PUBLIC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (in_take) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) out_item <= r;
	end

`ifndef NO_ASSERTIONS
	a_pub: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.routable_public ==
			(out_item.text_valid && out_item.range_code == RC_PUBLIC))
		else $error("public flag mismatch");
	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.text_valid |-> out_item.range_code == RC_INVALID)
		else $error("invalid code mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");
`endif

endmodule

// ===== sv/ip_text_parse_and_range_block.sv =====
// ----------------------------------------------------------------------------
// ip_text_parse_and_range_block
// ipv4 / ipv6 address text parser with special range classification
// ----------------------------------------------------------------------------
// one character enters per transaction, at one per cycle while not stalled;
// the front part updates its registered parse state on each character, and
// on the last character a registered parse snapshot goes into a four entry
// queue. the back part classifies it against the special range table and
// holds the result in an output register. input stalls only when the front
// snapshot and the queued ones reach the queue depth, under output stall only.
module ip_text_parse_and_range_block import iptp_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic    in_fire, snap_fire, q_full, q_valid, q_take;
	parsed_t snap, q_data;

	// occupancy counts the snapshot still in the front as well as the queued ones
	logic    q_full_r;
	logic [$clog2(QDEPTH+1)-1:0] occ_q;
	assign q_full_r = occ_q >= ($clog2(QDEPTH+1))'(QDEPTH);
	assign in_stall = q_full_r;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) occ_q <= '0;
		else occ_q <= occ_q + ($clog2(QDEPTH+1))'(in_fire && in_data.last_char)
			- ($clog2(QDEPTH+1))'(q_take);
	end

	iptp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_item(in_data),
		.snap_fire(snap_fire), .snap(snap)
	);

	iptp_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(snap_fire), .wr_data(snap),
		.full(q_full), .rd_valid(q_valid), .rd_en(q_take), .rd_data(q_data)
	);

	iptp_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid), .in_snap(q_data),
		.in_take(q_take), .out_valid(out_valid), .out_stall(out_stall),
		.out_item(out_data)
	);

`ifndef NO_ASSERTIONS
	a_qroom: assert property (@(posedge clk) disable iff (!arst_n)
		snap_fire |-> !q_full || q_take) else $error("snapshot lost");
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= ($clog2(QDEPTH+1))'(QDEPTH)) else $error("occupancy out of range");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.last_char |=> snap_fire) else $error("no snapshot");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// address text parser check: strings are fed one character per transaction,
// each marked string is parsed by an in-bench predictor and the classified
// result is compared field by field, under random gaps and output stall
// ----------------------------------------------------------------------------
module testbench;
	import iptp_pkg::*;

	// bench controls
	localparam int N_RANDOM_STR = 45;   // about 900 characters in total
	localparam int WATCHDOG     = 4000; // cycles without any transaction
	localparam int TAIL_CYCLES  = 8;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	ip_text_parse_and_range_block i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor state: a copy of the parser state
	// ------------------------------------------------------------------------
	logic [31:0] ps_octets;
	logic [7:0]  ps_dec;
	logic [1:0]  ps_dec_n;
	logic [1:0]  ps_dots;
	logic [15:0] ps_groups [8];
	logic [3:0]  ps_ngroups;
	logic [15:0] ps_hex;
	logic [2:0]  ps_hex_n;
	logic [3:0]  ps_dcolon;
	logic        ps_prev_colon;
	// parse flags
	logic f_colon, f_zone, f_err, f_started, f_segdot, f_v4err, f_hexerr, f_segused;

	out_item_t addr_expected [$];
	int        errors;

	task automatic seg_clear();
		ps_octets = '0; ps_dec = '0; ps_dec_n = '0; ps_dots = '0;
		ps_hex = '0; ps_hex_n = '0;
		f_segdot = 0; f_v4err = 0; f_hexerr = 0; f_segused = 0;
	endtask

	task automatic parser_clear();
		for (int i = 0; i < 8; i++) ps_groups[i] = '0;
		ps_ngroups = '0;
		ps_dcolon = NO_COMPRESS;
		ps_prev_colon = 0;
		f_colon = 0; f_zone = 0; f_err = 0; f_started = 0;
		seg_clear();
	endtask

	task automatic take_colon();
		f_colon = 1;
		if (ps_prev_colon) begin
			if (ps_dcolon != NO_COMPRESS) f_err = 1;
			else ps_dcolon = ps_ngroups;
		end else if (!f_segused) begin
			if (f_started) f_err = 1;
		end else if (f_segdot || f_hexerr || ps_hex_n == 0 || ps_ngroups >= 8) begin
			f_err = 1;
		end else begin
			ps_groups[ps_ngroups[2:0]] = ps_hex;
			ps_ngroups++;
		end
		ps_prev_colon = 1;
		f_started = 1;
		seg_clear();
	endtask

	task automatic take_char(input logic [7:0] c);
		logic [4:0] d;
		int         t;
		if (ps_prev_colon && ps_ngroups == 0 && ps_dcolon == NO_COMPRESS) f_err = 1;
		ps_prev_colon = 0;
		f_started = 1; f_segused = 1;
		if (c >= "0" && c <= "9") d = 5'(c - "0");
		else if (c >= "a" && c <= "f") d = 5'(c - "a" + 10);
		else if (c >= "A" && c <= "F") d = 5'(c - "A" + 10);
		else d = 5'd16;
		if (d > 15 || ps_hex_n >= 4) f_hexerr = 1;
		else begin
			ps_hex = {ps_hex[11:0], d[3:0]};
			ps_hex_n++;
		end
		if (c >= "0" && c <= "9") begin
			t = int'(ps_dec) * 10 + int'(c - "0");
			if ((ps_dec_n > 0 && ps_dec == 0) || ps_dec_n >= 3 || t > 255) f_v4err = 1;
			else begin
				ps_dec = 8'(t);
				ps_dec_n++;
			end
		end else if (c == ".") begin
			f_segdot = 1;
			if (ps_dec_n == 0 || ps_dots >= 3) f_v4err = 1;
			else begin
				ps_octets = {ps_octets[23:0], ps_dec};
				ps_dots++;
				ps_dec = '0;
				ps_dec_n = '0;
			end
		end else begin
			f_v4err = 1;
		end
	endtask

	function automatic logic [4:0] v4_range_of(input logic [31:0] a);
		logic [31:0] nets [15] = '{
			32'h00000000, 32'h0A000000, 32'h64400000, 32'h7F000000, 32'hA9FE0000,
			32'hAC100000, 32'hC0000000, 32'hC0000200, 32'hC0586300, 32'hC0A80000,
			32'hC6120000, 32'hC6336400, 32'hCB007100, 32'hE0000000, 32'hF0000000};
		int lens [15] = '{8, 8, 10, 8, 16, 12, 24, 24, 24, 16, 15, 24, 24, 4, 4};
		logic [31:0] m;
		for (int i = 0; i < 15; i++) begin
			m = 32'hFFFFFFFF << (32 - lens[i]);
			if ((a & m) == (nets[i] & m)) return RC_V4_BASE + 5'(i);
		end
		return RC_PUBLIC;
	endfunction

	function automatic logic quad_good();
		return !f_v4err && ps_dots == 3 && ps_dec_n > 0;
	endfunction

	// classification of the finished string
	function automatic out_item_t classify_text();
		out_item_t   r;
		logic [15:0] g [10];
		logic [15:0] w [8];
		int          n, left, right;
		logic        ok;
		logic [31:0] a;
		r = '0;
		r.range_code = RC_INVALID;
		ok = 0;
		a = {ps_octets[23:0], ps_dec};
		if (!f_started) begin
			ok = 0;
		end else if (!f_colon) begin
			if (quad_good()) begin
				r.text_valid = 1; r.is_v4 = 1;
				r.addr_low = {32'h0, a};
			end
		end else if (!f_err) begin
			for (int i = 0; i < 8; i++) g[i] = ps_groups[i];
			g[8] = '0; g[9] = '0;
			n = ps_ngroups;
			ok = 1;
			if (ps_prev_colon) ok = (ps_dcolon == ps_ngroups);
			else if (f_segdot) begin
				if (!quad_good() || n + 2 > 8) ok = 0;
				else begin
					g[n] = a[31:16]; g[n+1] = a[15:0]; n += 2;
				end
			end else begin
				if (f_hexerr || ps_hex_n == 0 || n >= 8) ok = 0;
				else begin
					g[n] = ps_hex; n++;
				end
			end
			if (ok) begin
				for (int i = 0; i < 8; i++) w[i] = '0;
				if (ps_dcolon == NO_COMPRESS) begin
					if (n != 8) ok = 0;
					else for (int i = 0; i < 8; i++) w[i] = g[i];
				end else if (n > 7 || ps_dcolon > n) begin
					ok = 0;
				end else begin
					left = ps_dcolon; right = n - ps_dcolon;
					for (int i = 0; i < left; i++) w[i] = g[i];
					for (int i = 0; i < right; i++) w[8 - right + i] = g[left + i];
				end
				if (ok) begin
					r.text_valid = 1;
					r.addr_high = {w[0], w[1], w[2], w[3]};
					r.addr_low  = {w[4], w[5], w[6], w[7]};
				end
			end
		end
		if (r.text_valid) begin
			if (r.is_v4) begin
				r.range_code = v4_range_of(r.addr_low[31:0]);
				r.is_loopback = (r.addr_low[31:24] == 8'd127);
			end else if (r.addr_high == 0 && r.addr_low == 0) r.range_code = RC_V6_UNSPEC;
			else if (r.addr_high == 0 && r.addr_low == 1) begin
				r.range_code = RC_V6_LOOP; r.is_loopback = 1;
			end else if (r.addr_high == 0 && r.addr_low[63:32] == 32'hFFFF) begin
				r.mapped_v4 = 1;
				r.range_code = v4_range_of(r.addr_low[31:0]);
			end else if (r.addr_high == 64'h0064FF9B00000000 && r.addr_low[63:32] == 0)
				r.range_code = RC_V6_NAT64;
			else if (r.addr_high == 64'h0100000000000000) r.range_code = RC_V6_DISC;
			else if (r.addr_high[63:32] == 32'h20010DB8) r.range_code = RC_V6_DOC;
			else if (r.addr_high[63:54] == 10'h3FA) r.range_code = RC_V6_LINK;
			else if (r.addr_high[63:57] == 7'h7E) r.range_code = RC_V6_ULA;
			else if (r.addr_high[63:56] == 8'hFF) r.range_code = RC_V6_MCAST;
			else r.range_code = RC_PUBLIC;
		end
		r.routable_public = r.text_valid && r.range_code == RC_PUBLIC;
		return r;
	endfunction

	// one accepted character: update the state, queue a result on the last one
	task automatic predict_char(input in_item_t it);
		if (!f_zone) begin
			if (it.char_code == "%") f_zone = 1;
			else if (it.char_code == ":") take_colon();
			else take_char(it.char_code);
		end
		if (it.last_char) begin
			addr_expected = {addr_expected, classify_text()};
			parser_clear();
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus strings: directed table, then random
	// ------------------------------------------------------------------------
	out_item_t bad;
	in_item_t  chars [$];   // characters waiting to be driven
	out_item_t typed_exp [$];
	logic      typed_has [$];
	logic      idle_off;
	logic      stop_in;

	function automatic out_item_t v4_res(input logic [31:0] a, input logic [4:0] rc);
		out_item_t r;
		r = '0;
		r.text_valid = 1; r.is_v4 = 1; r.addr_low = {32'h0, a};
		r.range_code = rc; r.is_loopback = (a[31:24] == 127);
		r.routable_public = (rc == RC_PUBLIC);
		return r;
	endfunction

	task automatic push_text(input string s, input logic has, input out_item_t e);
		in_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.char_code = s[i];
			it.last_char = (i == s.len() - 1);
			chars = {chars, it};
		end
		if (s.len() == 0) begin
			it.char_code = 8'h00; it.last_char = 1;
			chars = {chars, it};
		end
		typed_has = {typed_has, has};
		typed_exp = {typed_exp, e};
	endtask

	function automatic string rnd_dec();
		int v;
		v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 255);
		if ($urandom_range(0, 15) == 0) return $sformatf("0%0d", v);
		return $sformatf("%0d", v);
	endfunction

	function automatic string rnd_hex();
		int n;
		string s;
		n = $urandom_range(1, ($urandom_range(0, 15) == 0) ? 5 : 4);
		s = "";
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 2))
				0: s = {s, $sformatf("%0d", $urandom_range(0, 9))};
				1: s = {s, $sformatf("%c", "a" + $urandom_range(0, 5))};
				default: s = {s, $sformatf("%c", "A" + $urandom_range(0, 5))};
			endcase
		end
		return s;
	endfunction

	function automatic string rnd_v4();
		string s;
		s = {rnd_dec(), ".", rnd_dec(), ".", rnd_dec(), ".", rnd_dec()};
		case ($urandom_range(0, 9))
			0: s = {"10.", rnd_dec(), ".1.1"};
			1: s = {"192.168.", rnd_dec(), ".7"};
			2: s = {"127.0.0.", rnd_dec()};
			default: ;
		endcase
		return s;
	endfunction

	function automatic string rnd_v6();
		int    n, cpos;
		string s;
		logic  tail;
		n = $urandom_range(1, 8);
		tail = ($urandom_range(0, 4) == 0);
		cpos = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, n);
		s = "";
		case ($urandom_range(0, 7))
			0: s = "ffff:";
			1: s = "2001:db8:";
			2: s = "fe80:";
			3: s = "64:ff9b:";
			default: ;
		endcase
		for (int i = 0; i < n; i++) begin
			if (i == cpos) s = {s, (i == 0 && s.len() == 0) ? "::" : ":"};
			else if (i > 0) s = {s, ":"};
			s = {s, rnd_hex()};
		end
		if (cpos == n) s = {s, "::"};
		if (tail) s = {s, ":", rnd_v4()};
		if ($urandom_range(0, 9) == 0) s = {s, "%eth", rnd_hex()};
		return s;
	endfunction

	// random string, mostly well formed, some mangled
	function automatic string rnd_text();
		string s;
		int    p;
		s = ($urandom_range(0, 1) == 0) ? rnd_v4() : rnd_v6();
		if ($urandom_range(0, 4) == 0 && s.len() > 0) begin
			p = $urandom_range(0, s.len() - 1);
			s[p] = 8'($urandom_range(0, 255));
		end
		if ($urandom_range(0, 19) == 0) s = {s, ":"};
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------------
	int        watchdog;
	logic      sent_all;
	int        in_gap, out_gap;
	logic      in_stall_q;

	initial begin
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		arst_n = 0;
		errors = 0;
		idle_off = 0;
		stop_in = 0;
		sent_all = 0;
		parser_clear();
		bad = '0;
		bad.range_code = RC_INVALID;

		// directed strings
		push_text("0.0.0.0", 1, v4_res(32'h0, RC_V4_BASE));
		push_text("255.255.255.255", 1, v4_res(32'hFFFFFFFF, RC_V4_BASE + 5'd14));
		push_text("8.8.8.8", 1, v4_res(32'h08080808, RC_PUBLIC));
		push_text("127.0.0.1", 1, v4_res(32'h7F000001, RC_V4_BASE + 5'd3));
		push_text("1.2.3.4%eth0", 1, v4_res(32'h01020304, RC_PUBLIC));
		push_text("01.2.3.4", 1, bad);
		push_text("256.1.1.1", 1, bad);
		push_text("1.2.3", 1, bad);
		push_text("", 1, bad);
		push_text("%zone", 1, bad);
		push_text("::", 0, bad);
		push_text("::1", 0, bad);
		push_text("::ffff:192.168.1.1", 0, bad);
		push_text("64:ff9b::1.2.3.4", 0, bad);
		push_text("100::5", 0, bad);
		push_text("2001:db8::1", 0, bad);
		push_text("fe80::1%eth0", 0, bad);
		push_text("fd00::", 0, bad);
		push_text("FF02::1", 0, bad);
		push_text("1:2:3:4:5:6:7:8", 0, bad);
		push_text("1::2::3", 1, bad);
		push_text(":::", 1, bad);
		push_text(":1::", 1, bad);
		push_text("1:2:3:4:5:6:7:8::", 1, bad);
		push_text("1.2.3.4:5::", 1, bad);
		for (int i = 0; i < N_RANDOM_STR; i++) push_text(rnd_text(), 0, bad);
		// a few unmarked stray bytes of any value before a final string
		begin
			in_item_t it;
			for (int i = 0; i < 8; i++) begin
				it.char_code = 8'($urandom_range(0, 255)); it.last_char = 0;
				chars = {chars, it};
			end
			push_text(rnd_text(), 0, bad);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		in_gap = 0;
		while (chars.size() > 0) begin
			@(negedge clk);
			if (!in_valid || !in_stall_q) begin
				// previous transaction taken (or none pending)
				if (chars.size() < 60) idle_off = 1;
				if (chars.size() == 400 && !stop_in) begin
					// hold off until the block has drained
					in_valid = 0;
					stop_in = 1;
					while (addr_expected.size() > 0) @(negedge clk);
				end
				if (in_gap > 0) begin
					in_gap--;
					in_valid = 0;
				end else if (!idle_off && $urandom_range(0, 7) == 0) begin
					in_gap = $urandom_range(1, 10) - 1;
					in_valid = 0;
				end else begin
					in_data = chars.pop_front();
					in_valid = 1;
				end
			end
		end
		// wait for the final transaction to be taken
		do @(negedge clk); while (in_valid && in_stall_q);
		in_valid = 0;
		sent_all = 1;
	end

	// input stall as seen at the rising edge, kept for the sender
	always @(posedge clk) begin
		in_stall_q <= in_stall;
	end
	// latch acceptance at the edge itself, before any driving changes
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) predict_char(in_data);
		if (arst_n && out_valid && !out_stall) begin
			out_item_t e;
			out_item_t e_typed;
			logic      has_typed;
			if (addr_expected.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = addr_expected.pop_front();
				if (typed_has.size() > 0) begin
					has_typed = typed_has.pop_front();
					e_typed = typed_exp.pop_front();
					// typed rows are checked against their typed result
					if (has_typed) e = e_typed;
				end
				if (out_data.text_valid !== e.text_valid) begin
					$error("text_valid exp %0h got %0h", e.text_valid, out_data.text_valid); errors++;
				end
				if (out_data.is_v4 !== e.is_v4) begin
					$error("is_v4 exp %0h got %0h", e.is_v4, out_data.is_v4); errors++;
				end
				if (out_data.addr_high !== e.addr_high) begin
					$error("addr_high exp %h got %h", e.addr_high, out_data.addr_high); errors++;
				end
				if (out_data.addr_low !== e.addr_low) begin
					$error("addr_low exp %h got %h", e.addr_low, out_data.addr_low); errors++;
				end
				if (out_data.range_code !== e.range_code) begin
					$error("range_code exp %0d got %0d", e.range_code, out_data.range_code); errors++;
				end
				if (out_data.mapped_v4 !== e.mapped_v4) begin
					$error("mapped_v4 exp %0h got %0h", e.mapped_v4, out_data.mapped_v4); errors++;
				end
				if (out_data.is_loopback !== e.is_loopback) begin
					$error("is_loopback exp %0h got %0h", e.is_loopback, out_data.is_loopback); errors++;
				end
				if (out_data.routable_public !== e.routable_public) begin
					$error("routable_public exp %0h got %0h", e.routable_public,
						out_data.routable_public);
					errors++;
				end
			end
		end
	end

	// receiver stall bursts, driven at the falling edge
	initial begin
		out_gap = 0;
		forever begin
			@(negedge clk);
			if (out_gap > 0) begin
				out_gap--;
				out_stall = 1;
			end else if (!idle_off && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(1, 10) - 1;
				out_stall = 1;
			end else begin
				out_stall = 0;
			end
		end
	end

	// watchdog and end of run
	initial begin
		watchdog = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) watchdog = 0;
			else watchdog++;
			if (watchdog >= WATCHDOG) begin
				$display("FAILURE");
				$finish;
			end
			if (sent_all && addr_expected.size() == 0) begin
				repeat (TAIL_CYCLES) @(posedge clk);
				if (errors == 0 && addr_expected.size() == 0) begin
					$display("SUCCESS");
				end else begin
					$display("FAILURE");
				end
				$finish;
			end
		end
	end

endmodule

// ===== sim.f =====
sv/iptp_pkg.sv
sv/iptp_front.sv
sv/iptp_fifo.sv
sv/iptp_back.sv
sv/ip_text_parse_and_range_block.sv
verif/testbench.sv
